### rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence at the same clock edge.
`define CCA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence at the next clock edge.
`define CCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cca_pkg.sv
// Shared types, codes and constants of the cluster chain allocator.
package cca_pkg;

    localparam int MODE_W = 3;
    localparam int IDX_W  = 16;
    localparam int LINK_W = 28;
    localparam int CNT_W  = 17;
    localparam int ST_W   = 2;

    localparam int MAX_CLUSTERS_DEF = 65536;
    localparam int TABLE_LIMIT      = 65536;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 17'h10000;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 17'h1FFFF;

    localparam logic [LINK_W-1:0] EOC_MIN  = 28'hFFFFFF8;
    localparam logic [LINK_W-1:0] EOC_MARK = 28'hFFFFFFF;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RECOUNT = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [ST_W-1:0] ST_CORRUPT = 2'd3;

    // One result item as it leaves the engine
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [LINK_W-1:0] value_out;
        logic [CNT_W-1:0]  free_tally;
        logic [IDX_W-1:0]  scan_start;
    } t_result;

endpackage

### rtl/cluster_chain_allocator.sv
// Cluster link table allocator: one item at a time; read, write, allocate, free and recount.
// Allocate scans one entry after another from the hint, wrapping once to cluster 2.
// Recount scans every entry once. Free chain follows the chain one link after another.
// A result waits in the output register while the next item is taken.
// Reset: synchronous; afterward a clearing pass over all DEPTH entries (65536 by default)
// zeroes the table, with o_ready low; configuration writes are taken throughout.
`include "assert_macros.svh"

module cluster_chain_allocator
    import cca_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_cluster_index,
    input  logic [LINK_W-1:0] i_entry_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [LINK_W-1:0] o_value_out,
    output logic [CNT_W-1:0]  o_free_tally,
    output logic [IDX_W-1:0]  o_scan_start
);

    localparam int DEPTH = (MAX_CLUSTERS > TABLE_LIMIT) ? TABLE_LIMIT : MAX_CLUSTERS;
    localparam int AW    = $clog2(DEPTH);

    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  eff_total;
    logic              r_out_vld;
    t_result           r_out;
    t_result           eng_res;
    logic              eng_res_vld;
    logic              res_take;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [LINK_W-1:0] rd_data;

    // Hold the cluster bound
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (i_cfg_valid) begin
            r_total <= i_cfg_data;
        end
    end

    assign eff_total = (r_total > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_total;

    cca_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cca_engine #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_total     (eff_total),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_mode      (i_mode),
        .i_idx       (i_cluster_index),
        .i_val       (i_entry_value),
        .o_res_valid (eng_res_vld),
        .i_res_take  (res_take),
        .o_res       (eng_res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Output register: load a finished result when the slot is free or draining
    assign res_take = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (eng_res_vld && res_take) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_vld && res_take) begin
            r_out <= eng_res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_out.status;
    assign o_value_out  = r_out.value_out;
    assign o_free_tally = r_out.free_tally;
    assign o_scan_start = r_out.scan_start;

    // Checks on the sequencing and the result contents
    `CCA_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input taken while busy")
    `CCA_ASSERT_SAME(a_error_value_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_value_out == '0, "error result carries a value")
    `CCA_ASSERT_SAME(a_hint_floor, i_clk, i_rst_n, o_valid, o_scan_start >= IDX_W'(2), "search hint below cluster two")

endmodule

### rtl/cca_link_ram.sv
// Link table memory: one write and one registered read port, with same-cycle forwarding.
module cca_link_ram
    import cca_pkg::*;
#(
    parameter int DEPTH = MAX_CLUSTERS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [LINK_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [LINK_W-1:0] o_rd_data
);

    logic [LINK_W-1:0] r_mem [DEPTH];
    logic [LINK_W-1:0] r_q;
    logic              r_fwd_hit;
    logic [LINK_W-1:0] r_fwd_data;

    // Store the write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read old contents; remember a write to the same entry for forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

### rtl/cca_engine.sv
// Operation sequencer: clearing pass, read, write, allocate scan, chain free and recount.
module cca_engine
    import cca_pkg::*;
#(
    parameter int DEPTH = MAX_CLUSTERS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_total,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [LINK_W-1:0] i_val,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output t_result           o_res,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [LINK_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [LINK_W-1:0] i_rd_data
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FREE  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state            r_state,      n_state;
    logic [AW-1:0]     r_clr_addr,   n_clr_addr;
    logic              r_op_alloc,   n_op_alloc;
    logic              r_phase,      n_phase;
    logic [CNT_W-1:0]  r_iss,        n_iss;
    logic [CNT_W-1:0]  r_lim,        n_lim;
    logic [CNT_W-1:0]  r_start,      n_start;
    logic              r_chk_vld,    n_chk_vld;
    logic [IDX_W-1:0]  r_chk_addr,   n_chk_addr;
    logic [IDX_W-1:0]  r_cur,        n_cur;
    logic [IDX_W-1:0]  r_least,      n_least;
    logic [CNT_W-1:0]  r_cnt,        n_cnt;
    logic [IDX_W-1:0]  r_first,      n_first;
    logic [CNT_W-1:0]  r_free_total, n_free_total;
    logic [IDX_W-1:0]  r_hint,       n_hint;
    t_result           r_res,        n_res;

    logic              fin;
    logic [ST_W-1:0]   fin_st;
    logic [LINK_W-1:0] fin_val;
    logic              hit;
    logic [CNT_W-1:0]  alloc_nxt;
    logic [IDX_W-1:0]  least_new;

    function automatic logic in_range(input logic [LINK_W-1:0] c, input logic [CNT_W-1:0] t);
        return (c >= LINK_W'(2)) && (c < LINK_W'(t));
    endfunction

    function automatic logic [IDX_W-1:0] lower_hint(input logic [IDX_W-1:0] lst,
                                                    input logic [IDX_W-1:0] hint);
        return ((lst != '0) && (lst < hint)) ? lst : hint;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    assign hit       = r_chk_vld && (i_rd_data == '0);
    assign alloc_nxt = {1'b0, r_chk_addr} + CNT_W'(1);
    assign least_new = ((r_least == '0) || (r_cur < r_least)) ? r_cur : r_least;

    // Sequence the operation and drive the table ports
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op_alloc   = r_op_alloc;
        n_phase      = r_phase;
        n_iss        = r_iss;
        n_lim        = r_lim;
        n_start      = r_start;
        n_chk_vld    = r_chk_vld;
        n_chk_addr   = r_chk_addr;
        n_cur        = r_cur;
        n_least      = r_least;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_free_total = r_free_total;
        n_hint       = r_hint;
        n_res        = r_res;
        fin          = 1'b0;
        fin_st       = ST_OK;
        fin_val      = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = '0;
        o_wr_data    = '0;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;

        case (r_state)
            S_CLEAR: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_READ: begin
                            if (in_range(LINK_W'(i_idx), i_total)) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = i_idx[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                fin    = 1'b1;
                                fin_st = ST_RANGE;
                            end
                        end
                        MODE_WRITE: begin
                            fin = 1'b1;
                            if (in_range(LINK_W'(i_idx), i_total)) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = i_idx[AW-1:0];
                                o_wr_data = i_val;
                            end else begin
                                fin_st = ST_RANGE;
                            end
                        end
                        MODE_ALLOC: begin
                            n_op_alloc = 1'b1;
                            n_phase    = 1'b0;
                            n_iss      = in_range(LINK_W'(r_hint), i_total) ?
                                         CNT_W'(r_hint) : CNT_W'(2);
                            n_start    = n_iss;
                            n_lim      = i_total;
                            n_chk_vld  = 1'b0;
                            n_state    = S_SCAN;
                        end
                        MODE_FREE: begin
                            if (in_range(LINK_W'(i_idx), i_total)) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = i_idx[AW-1:0];
                                n_cur     = i_idx;
                                n_least   = '0;
                                n_state   = S_FREE;
                            end else begin
                                fin    = 1'b1;
                                fin_st = ST_RANGE;
                            end
                        end
                        MODE_RECOUNT: begin
                            n_op_alloc = 1'b0;
                            n_phase    = 1'b1;
                            n_iss      = CNT_W'(2);
                            n_lim      = i_total;
                            n_cnt      = '0;
                            n_first    = '0;
                            n_chk_vld  = 1'b0;
                            n_state    = S_SCAN;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                fin     = 1'b1;
                fin_val = i_rd_data;
            end

            S_SCAN: begin
                if (r_op_alloc && hit) begin
                    // Claim the first free entry
                    o_wr_en      = 1'b1;
                    o_wr_addr    = r_chk_addr[AW-1:0];
                    o_wr_data    = EOC_MARK;
                    n_chk_vld    = 1'b0;
                    n_free_total = (r_free_total != '0) ? r_free_total - CNT_W'(1) : '0;
                    n_hint       = (alloc_nxt < i_total) ? alloc_nxt[IDX_W-1:0] : IDX_W'(2);
                    fin          = 1'b1;
                    fin_val      = LINK_W'(r_chk_addr);
                end else begin
                    // Tally free entries for a recount
                    if (!r_op_alloc && hit) begin
                        n_cnt = r_cnt + CNT_W'(1);
                        if (r_first == '0) begin
                            n_first = r_chk_addr;
                        end
                    end
                    // Issue the next read, or close the phase once drained
                    if (r_iss < r_lim) begin
                        o_rd_en    = 1'b1;
                        o_rd_addr  = r_iss[AW-1:0];
                        n_chk_vld  = 1'b1;
                        n_chk_addr = r_iss[IDX_W-1:0];
                        n_iss      = r_iss + CNT_W'(1);
                    end else begin
                        n_chk_vld = 1'b0;
                        if (!r_chk_vld) begin
                            if (!r_phase) begin
                                n_phase = 1'b1;
                                n_iss   = CNT_W'(2);
                                n_lim   = r_start;
                            end else if (r_op_alloc) begin
                                fin    = 1'b1;
                                fin_st = ST_FULL;
                            end else begin
                                n_free_total = r_cnt;
                                n_hint       = (r_first != '0) ? r_first : IDX_W'(2);
                                fin          = 1'b1;
                            end
                        end
                    end
                end
            end

            S_FREE: begin
                if (i_rd_data == '0) begin
                    // Entry already free: stop without counting it
                    fin    = 1'b1;
                    fin_st = ST_CORRUPT;
                    n_hint = lower_hint(r_least, r_hint);
                end else begin
                    o_wr_en      = 1'b1;
                    o_wr_addr    = r_cur[AW-1:0];
                    o_wr_data    = '0;
                    n_free_total = (r_free_total < COUNT_MAX) ?
                                   r_free_total + CNT_W'(1) : COUNT_MAX;
                    if (i_rd_data >= EOC_MIN) begin
                        fin    = 1'b1;
                        n_hint = lower_hint(least_new, r_hint);
                    end else if (!in_range(i_rd_data, i_total)) begin
                        fin    = 1'b1;
                        fin_st = ST_CORRUPT;
                        n_hint = lower_hint(least_new, r_hint);
                    end else begin
                        // Follow the link
                        n_cur     = i_rd_data[IDX_W-1:0];
                        n_least   = least_new;
                        o_rd_en   = 1'b1;
                        o_rd_addr = i_rd_data[AW-1:0];
                    end
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capture the result with the count and hint left by the operation
        if (fin) begin
            n_res.status     = fin_st;
            n_res.value_out  = fin_val;
            n_res.free_tally = n_free_total;
            n_res.scan_start = n_hint;
            n_state          = S_DONE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_chk_vld    <= 1'b0;
            r_free_total <= '0;
            r_hint       <= IDX_W'(2);
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_chk_vld    <= n_chk_vld;
            r_free_total <= n_free_total;
            r_hint       <= n_hint;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op_alloc <= n_op_alloc;
        r_phase    <= n_phase;
        r_iss      <= n_iss;
        r_lim      <= n_lim;
        r_start    <= n_start;
        r_chk_addr <= n_chk_addr;
        r_cur      <= n_cur;
        r_least    <= n_least;
        r_cnt      <= n_cnt;
        r_first    <= n_first;
        r_res      <= n_res;
    end

endmodule

### tb/sv/cluster_chain_allocator_tb.sv
// Self-checking testbench for the cluster chain allocator: directed table, then random phases.
`timescale 1ns / 100ps

module cluster_chain_allocator_tb;
    import cca_pkg::*;

    // Modes the block ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed plan; want is used only when typed is set
    typedef struct packed {
        t_row_kind         kind;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic [LINK_W-1:0] val;
        logic              typed;
        t_result           want;
    } t_plan_row;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_valid     = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data      = '0;
    logic              i_valid         = 1'b0;
    logic              o_ready;
    logic [MODE_W-1:0] i_mode          = '0;
    logic [IDX_W-1:0]  i_cluster_index = '0;
    logic [LINK_W-1:0] i_entry_value   = '0;
    logic              o_valid;
    logic              i_ready         = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [LINK_W-1:0] o_value_out;
    logic [CNT_W-1:0]  o_free_tally;
    logic [IDX_W-1:0]  o_scan_start;

    // Mirror of the block's state
    logic [LINK_W-1:0] links [TABLE_LIMIT];
    logic [CNT_W-1:0]  free_clusters = '0;
    logic [IDX_W-1:0]  hint_idx      = 16'd2;
    logic [CNT_W-1:0]  total_reg     = TOTAL_RESET;

    t_result   op_results_q [$];
    t_plan_row plan_q [$];
    int        bad_results   = 0;
    int        items_sent    = 0;
    int        snd_idle_pct  = 0;
    int        rcv_idle_pct  = 0;

    cluster_chain_allocator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_cluster_index (i_cluster_index),
        .i_entry_value   (i_entry_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_value_out     (o_value_out),
        .o_free_tally    (o_free_tally),
        .o_scan_start    (o_scan_start)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int cur_limit();
        return (int'(total_reg) > TABLE_LIMIT) ? TABLE_LIMIT : int'(total_reg);
    endfunction

    function automatic bit is_cluster(input int c, input int lim);
        return c >= 2 && c < lim;
    endfunction

    // Apply one operation to the mirrored state and return the result it gives
    function automatic t_result cluster_op_result(input logic [MODE_W-1:0] mode,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [LINK_W-1:0] val);
        t_result           r;
        int                lim, start, found, cur, least, cnt, c;
        bit                done;
        logic [LINK_W-1:0] link;
        lim = cur_limit();
        r = '0;
        r.status = ST_OK;
        case (mode)
            MODE_READ, MODE_WRITE: begin
                if (!is_cluster(int'(idx), lim))
                    r.status = ST_RANGE;
                else if (mode == MODE_READ)
                    r.value_out = links[idx];
                else
                    links[idx] = val;
            end
            MODE_ALLOC: begin
                // search from the hint, then wrap once to cluster 2
                start = is_cluster(int'(hint_idx), lim) ? int'(hint_idx) : 2;
                found = 0;
                for (c = start; c < lim && found == 0; c++)
                    if (links[c] == '0) found = c;
                for (c = 2; c < start && found == 0; c++)
                    if (links[c] == '0) found = c;
                if (found == 0) begin
                    r.status = ST_FULL;
                end else begin
                    links[found] = EOC_MARK;
                    r.value_out = LINK_W'(found);
                    if (free_clusters != '0) free_clusters--;
                    hint_idx = (found + 1 < lim) ? IDX_W'(found + 1) : 16'd2;
                end
            end
            MODE_FREE: begin
                if (!is_cluster(int'(idx), lim)) begin
                    r.status = ST_RANGE;
                end else begin
                    // walk the chain, zeroing each entry until end of chain or a bad link
                    cur = int'(idx);
                    least = 0;
                    done = 1'b0;
                    while (!done) begin
                        link = links[cur];
                        if (link == '0) begin
                            r.status = ST_CORRUPT;
                            done = 1'b1;
                        end else begin
                            links[cur] = '0;
                            if (free_clusters != COUNT_MAX) free_clusters++;
                            if (least == 0 || cur < least) least = cur;
                            if (link >= EOC_MIN) begin
                                done = 1'b1;
                            end else if (!is_cluster(int'(link), lim)) begin
                                r.status = ST_CORRUPT;
                                done = 1'b1;
                            end else begin
                                cur = int'(link);
                            end
                        end
                    end
                    if (least != 0 && least < int'(hint_idx)) hint_idx = IDX_W'(least);
                end
            end
            MODE_RECOUNT: begin
                cnt = 0;
                found = 0;
                for (c = 2; c < lim; c++) begin
                    if (links[c] == '0) begin
                        cnt++;
                        if (found == 0) found = c;
                    end
                end
                free_clusters = CNT_W'(cnt);
                hint_idx = (found != 0) ? IDX_W'(found) : 16'd2;
            end
            default: ;
        endcase
        r.free_tally = free_clusters;
        r.scan_start = hint_idx;
        return r;
    endfunction

    function automatic t_plan_row op_row(input logic [MODE_W-1:0] mode,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [LINK_W-1:0] val);
        t_plan_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.mode = mode;
        row.idx = idx;
        row.val = val;
        return row;
    endfunction

    function automatic t_plan_row chk_row(input logic [MODE_W-1:0] mode,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [LINK_W-1:0] val,
                                          input logic [ST_W-1:0] st,
                                          input logic [LINK_W-1:0] vout,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic [IDX_W-1:0] hint);
        t_plan_row row;
        row = op_row(mode, idx, val);
        row.typed = 1'b1;
        row.want = {st, vout, cnt, hint};
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input logic [CNT_W-1:0] total);
        t_plan_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.val = LINK_W'(total);
        return row;
    endfunction

    // Present one item and hold it until the transfer
    task automatic xfer_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [LINK_W-1:0] val);
        while ($urandom_range(99, 0) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_cluster_index <= idx;
        i_entry_value <= val;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                            input logic [LINK_W-1:0] val, output t_result pred);
        xfer_item(mode, idx, val);
        pred = cluster_op_result(mode, idx, val);
        op_results_q.push_back(pred);
    endtask

    // Drain all results, then write the cluster bound
    task automatic write_total(input logic [CNT_W-1:0] total);
        i_valid <= 1'b0;
        while (op_results_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= total;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        total_reg = total;
    endtask

    // Mostly well-formed chain and allocate sequences, with broken chains and noise mixed in
    task automatic run_random(input int n_items, input bit big);
        int                first_item, kind, k, n, i, lim;
        int                chn [8];
        logic [LINK_W-1:0] tail, wval;
        logic [MODE_W-1:0] m;
        t_result           r;
        first_item = items_sent;
        while (items_sent - first_item < n_items) begin
            lim = cur_limit();
            kind = $urandom_range(99, 0);
            if (kind < 30) begin
                // build a chain by writes and free it from its head
                k = $urandom_range(6, 1);
                for (i = 0; i < k; i++) chn[i] = $urandom_range(lim - 1, 2);
                for (i = 0; i < k - 1; i++)
                    issue_op(MODE_WRITE, IDX_W'(chn[i]), LINK_W'(chn[i + 1]), r);
                case ($urandom_range(9, 0))
                    7: tail = 28'd1;
                    8: tail = LINK_W'($urandom_range(int'(EOC_MIN) - 1, lim));
                    9: tail = '0;
                    default: tail = EOC_MIN + LINK_W'($urandom_range(7, 0));
                endcase
                issue_op(MODE_WRITE, IDX_W'(chn[k - 1]), tail, r);
                if ($urandom_range(1, 0))
                    issue_op(MODE_READ, IDX_W'(chn[0]), LINK_W'($urandom()), r);
                issue_op(MODE_FREE, IDX_W'(chn[0]), LINK_W'($urandom()), r);
            end else if (kind < 50) begin
                // allocate a few clusters, usually link them and hand them back
                k = $urandom_range(4, 1);
                n = 0;
                for (i = 0; i < k; i++) begin
                    issue_op(MODE_ALLOC, IDX_W'($urandom()), LINK_W'($urandom()), r);
                    if (r.status == ST_OK) begin
                        chn[n] = int'(r.value_out);
                        n++;
                    end
                end
                if (n > 0 && $urandom_range(9, 0) < 6) begin
                    for (i = 0; i < n - 1; i++)
                        issue_op(MODE_WRITE, IDX_W'(chn[i]), LINK_W'(chn[i + 1]), r);
                    issue_op(MODE_FREE, IDX_W'(chn[0]), LINK_W'($urandom()), r);
                end
            end else if (kind < 58 && !big) begin
                issue_op(MODE_RECOUNT, IDX_W'($urandom()), LINK_W'($urandom()), r);
            end else if (kind < 78) begin
                // single read or write of a cluster in range
                case ($urandom_range(3, 0))
                    0: wval = LINK_W'($urandom());
                    1: wval = LINK_W'($urandom_range(lim - 1, 2));
                    2: wval = '0;
                    default: wval = EOC_MIN + LINK_W'($urandom_range(7, 0));
                endcase
                issue_op($urandom_range(1, 0) ? MODE_WRITE : MODE_READ,
                         IDX_W'($urandom_range(lim - 1, 2)), wval, r);
            end else begin
                // any mode (no recount on a big table), any index, any value
                m = MODE_W'($urandom_range(7, 0));
                if (big && m == MODE_RECOUNT) m = MODE_READ;
                issue_op(m, IDX_W'($urandom()), LINK_W'($urandom()), r);
            end
        end
    endtask

    // Check each result transfer against the oldest expectation; randomize ready
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = {o_status, o_value_out, o_free_tally, o_scan_start};
            if (op_results_q.size() == 0) begin
                if (bad_results < 10)
                    $display("%0t: result with nothing pending: status %0d value %h count %0d hint %0d",
                             $realtime, got.status, got.value_out, got.free_tally, got.scan_start);
                bad_results++;
            end else begin
                want = op_results_q.pop_front();
                if (got.status !== want.status || got.value_out !== want.value_out ||
                    got.free_tally !== want.free_tally || got.scan_start !== want.scan_start) begin
                    if (bad_results < 10)
                        $display("%0t: mismatch exp/act status %0d/%0d value %h/%h count %0d/%0d hint %0d/%0d",
                                 $realtime, want.status, got.status, want.value_out, got.value_out,
                                 want.free_tally, got.free_tally, want.scan_start, got.scan_start);
                    bad_results++;
                end
            end
        end
        i_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
    end

    initial begin : stimulus
        t_plan_row row;
        t_result   pred;
        int        tot;
        for (int n = 0; n < TABLE_LIMIT; n++) links[n] = '0;
        snd_idle_pct = 31;
        rcv_idle_pct = 72;

        // Hold reset, then release
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan: range errors, extremes, chain errors, unused modes, small tables
        plan_q.push_back(chk_row(MODE_READ, 16'd0, 28'd0, ST_RANGE, 28'd0, 17'd0, 16'd2));
        plan_q.push_back(chk_row(MODE_WRITE, 16'd1, 28'hABCDEF0, ST_RANGE, 28'd0, 17'd0, 16'd2));
        plan_q.push_back(op_row(MODE_WRITE, 16'hFFFF, 28'hFFFFFFF));
        plan_q.push_back(chk_row(MODE_READ, 16'hFFFF, 28'd0, ST_OK, 28'hFFFFFFF, 17'd0, 16'd2));
        plan_q.push_back(chk_row(MODE_ALLOC, 16'd0, 28'd0, ST_OK, 28'd2, 17'd0, 16'd3));
        plan_q.push_back(op_row(MODE_WRITE, 16'd3, 28'd4));
        plan_q.push_back(op_row(MODE_WRITE, 16'd4, EOC_MIN));
        plan_q.push_back(op_row(MODE_FREE, 16'd3, 28'd0));
        plan_q.push_back(chk_row(MODE_FREE, 16'd3, 28'd0, ST_CORRUPT, 28'd0, 17'd2, 16'd3));
        plan_q.push_back(op_row(MODE_WRITE, 16'd5, 28'd1));
        plan_q.push_back(chk_row(MODE_FREE, 16'd5, 28'd0, ST_CORRUPT, 28'd0, 17'd3, 16'd3));
        plan_q.push_back(op_row(MODE_WRITE, 16'd2, 28'h1234567));
        plan_q.push_back(chk_row(MODE_FREE, 16'd2, 28'd0, ST_CORRUPT, 28'd0, 17'd4, 16'd2));
        plan_q.push_back(chk_row(MODE_RECOUNT, 16'd0, 28'd0, ST_OK, 28'd0, 17'd65533, 16'd2));
        plan_q.push_back(chk_row(MODE_UNUSED_LO, 16'hFFFF, 28'hFFFFFFF,
                                 ST_OK, 28'd0, 17'd65533, 16'd2));
        plan_q.push_back(chk_row(MODE_UNUSED_HI, 16'h5555, 28'hAAAAAAA,
                                 ST_OK, 28'd0, 17'd65533, 16'd2));
        plan_q.push_back(cfg_row(17'd6));
        plan_q.push_back(op_row(MODE_ALLOC, 16'd0, 28'd0));
        plan_q.push_back(op_row(MODE_ALLOC, 16'd0, 28'd0));
        plan_q.push_back(op_row(MODE_ALLOC, 16'd0, 28'd0));
        // shrink below the hint so the next search restarts at cluster 2
        plan_q.push_back(cfg_row(17'd4));
        plan_q.push_back(op_row(MODE_WRITE, 16'd2, 28'd0));
        plan_q.push_back(op_row(MODE_ALLOC, 16'd0, 28'd0));
        plan_q.push_back(chk_row(MODE_ALLOC, 16'd0, 28'd0, ST_FULL, 28'd0, 17'd65529, 16'd3));
        plan_q.push_back(op_row(MODE_FREE, 16'd3, 28'd0));
        // allocating the last cluster wraps the hint back to 2
        plan_q.push_back(op_row(MODE_ALLOC, 16'd0, 28'd0));

        foreach (plan_q[n]) begin
            row = plan_q[n];
            if (row.kind == ROW_CFG) begin
                write_total(row.val[CNT_W-1:0]);
            end else begin
                xfer_item(row.mode, row.idx, row.val);
                pred = cluster_op_result(row.mode, row.idx, row.val);
                op_results_q.push_back(row.typed ? row.want : pred);
            end
        end

        // Random phases over several table sizes and idle patterns
        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 3) begin
                snd_idle_pct = 31;
                rcv_idle_pct = 72;
            end else if (ph < 6) begin
                snd_idle_pct = 72;
                rcv_idle_pct = 31;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (ph)
                0: tot = 3;
                1: tot = 19;
                2: tot = 64;
                3: tot = 65536;
                4: tot = 257;
                5: tot = 5;
                6: tot = 130;
                7: tot = 40;
                default: tot = 4096;
            endcase
            write_total(CNT_W'(tot));
            run_random(192, tot > 8192);
        end

        // Drain, then watch for stray results
        i_valid <= 1'b0;
        while (op_results_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (bad_results == 0 && op_results_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/cca_pkg.sv
rtl/cca_link_ram.sv
rtl/cca_engine.sv
rtl/cluster_chain_allocator.sv
tb/sv/cluster_chain_allocator_tb.sv
